### src/cjhi_pkg.sv
package cjhi_pkg;

  localparam int JOINTS = 6;
  localparam int CFG_IDX_W = 3;

  localparam int FRAC = 20;
  localparam int QUO_W = 31;
  localparam int PM_SHIFT = QUO_W - FRAC;
  localparam int A_W = 2 * QUO_W - FRAC;
  localparam int A_LO_W = 21;
  localparam int A_HI_W = A_W - A_LO_W;
  localparam int BM_W = 33;
  localparam int HM_W = 43;
  localparam int HM_LO_W = 22;
  localparam int HM_HI_W = HM_W - HM_LO_W;
  localparam int LIMIT_EXP = 62;

  localparam int DIV_SPS = 4;
  localparam int DIV_STAGES = (QUO_W + DIV_SPS - 1) / DIV_SPS;

  localparam int ST_DIV = 2;
  localparam int ST_POLY = ST_DIV + DIV_STAGES;
  localparam int ST_LANE = ST_POLY + 3;
  localparam int STAGES = ST_LANE + 3;

  localparam logic signed [31:0] HALF_PI = 32'sd102944;
  localparam int NEG_HOME_JOINT = 1;

  typedef struct packed {
    logic bad;
    logic uneg;
    logic pmh;
  } front_flags_t;

  typedef struct packed {
    logic huge;
    logic hneg;
    logic [HM_W-1:0] hm;
  } hcoef_t;

  function automatic logic signed [31:0] home_reset(input int j);
    return (j == NEG_HOME_JOINT) ? -HALF_PI : HALF_PI;
  endfunction

endpackage

### src/cjhi_front.sv
module cjhi_front #(
  parameter int AW = 20,
  parameter int TW = 24
) (
  input  logic                        clk,
  input  logic [1:0]                  en,
  input  logic signed [AW-1:0]        home [cjhi_pkg::JOINTS],
  input  logic signed [AW-1:0]        start [cjhi_pkg::JOINTS],
  input  logic [TW-1:0]               time_now,
  input  logic [TW-1:0]               time_begin,
  input  logic [TW-1:0]               time_finish,
  output logic signed [AW-1:0]        angle [cjhi_pkg::JOINTS],
  output logic [AW-1:0]               dmag [cjhi_pkg::JOINTS],
  output logic [cjhi_pkg::JOINTS-1:0] dneg,
  output logic [TW-1:0]               umag,
  output logic [TW-1:0]               tspan,
  output cjhi_pkg::front_flags_t      flags
);
  import cjhi_pkg::*;

  logic [TW:0]          tdiff;
  logic [TW:0]          udiff;
  logic [AW:0]          disp [JOINTS];
  logic signed [AW-1:0] start1 [JOINTS];

  logic [TW-1:0]        umag_next;
  logic [TW-1:0]        tspan_next;
  front_flags_t         flags_next;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      tdiff <= {1'b0, time_finish} - {1'b0, time_begin};
      udiff <= {1'b0, time_now} - {1'b0, time_begin};
      for (int j = 0; j < JOINTS; j++) begin
        disp[j] <= {home[j][AW-1], home[j]} - {start[j][AW-1], start[j]};
        start1[j] <= start[j];
      end
    end
  end

  always_comb begin
    tspan_next = tdiff[TW-1:0];
    flags_next.bad = tdiff[TW] || (tdiff == '0);
    flags_next.uneg = udiff[TW];
    if (udiff[TW]) begin
      umag_next = TW'(-udiff);
    end else begin
      umag_next = udiff[TW-1:0];
    end
    flags_next.pmh = {PM_SHIFT'(0), umag_next} >= {tspan_next, PM_SHIFT'(0)};
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      umag <= umag_next;
      tspan <= tspan_next;
      flags <= flags_next;
      for (int j = 0; j < JOINTS; j++) begin
        angle[j] <= start1[j];
        dneg[j] <= disp[j][AW];
        dmag[j] <= disp[j][AW] ? AW'(-disp[j]) : disp[j][AW-1:0];
      end
    end
  end

endmodule

### src/cjhi_div.sv
module cjhi_div #(
  parameter int TW = 24,
  parameter int SW = 1
) (
  input  logic                            clk,
  input  logic [cjhi_pkg::DIV_STAGES-1:0] en,
  input  logic [TW-1:0]                   tspan,
  input  logic [TW-1:0]                   umag,
  input  logic [SW-1:0]                   side_in,
  output logic [cjhi_pkg::QUO_W-1:0]      quo,
  output logic [SW-1:0]                   side_out
);
  import cjhi_pkg::*;

  logic [TW-1:0]    rem [DIV_STAGES];
  logic [TW-1:0]    tdiv [DIV_STAGES];
  logic [QUO_W-1:0] qn [DIV_STAGES];
  logic [SW-1:0]    side [DIV_STAGES];

  logic [TW-1:0]    rem0;
  logic [QUO_W-1:0] qn0;

  assign rem0 = TW'(umag >> PM_SHIFT);
  assign qn0 = {umag[PM_SHIFT-1:0], FRAC'(0)};

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    logic [TW-1:0]    rem_in;
    logic [TW-1:0]    t_in;
    logic [QUO_W-1:0] qn_in;
    logic [SW-1:0]    side_i;
    logic [TW-1:0]    rem_next;
    logic [QUO_W-1:0] qn_next;

    if (g == 0) begin : g_first
      assign rem_in = rem0;
      assign t_in = tspan;
      assign qn_in = qn0;
      assign side_i = side_in;
    end else begin : g_rest
      assign rem_in = rem[g-1];
      assign t_in = tdiv[g-1];
      assign qn_in = qn[g-1];
      assign side_i = side[g-1];
    end

    always_comb begin
      logic [TW:0] r2;
      r2 = '0;
      rem_next = rem_in;
      qn_next = qn_in;
      for (int j = 0; j < DIV_SPS; j++) begin
        if (g * DIV_SPS + j < QUO_W) begin
          r2 = {rem_next, qn_next[QUO_W-1]};
          if (r2 >= {1'b0, t_in}) begin
            r2 = r2 - {1'b0, t_in};
            qn_next = {qn_next[QUO_W-2:0], 1'b1};
          end else begin
            qn_next = {qn_next[QUO_W-2:0], 1'b0};
          end
          rem_next = r2[TW-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[g]) begin
        rem[g] <= rem_next;
        qn[g] <= qn_next;
        tdiv[g] <= t_in;
        side[g] <= side_i;
      end
    end
  end

  assign quo = qn[DIV_STAGES-1];
  assign side_out = side[DIV_STAGES-1];

endmodule

### src/cjhi_poly.sv
module cjhi_poly #(
  parameter int SW = 1
) (
  input  logic                       clk,
  input  logic [2:0]                 en,
  input  logic [cjhi_pkg::QUO_W-1:0] quo,
  input  cjhi_pkg::front_flags_t     flags_in,
  input  logic [SW-1:0]              side_in,
  output cjhi_pkg::hcoef_t           coef,
  output logic                       bad,
  output logic [SW-1:0]              side_out
);
  import cjhi_pkg::*;

  localparam int PP_W = A_HI_W + BM_W;
  localparam int PROD_W = A_W + BM_W;
  localparam logic [BM_W:0] B_BASE = (BM_W + 1)'(3) << FRAC;
  localparam logic [PROD_W-1:0] LIMIT = PROD_W'(1) << LIMIT_EXP;

  logic [2*QUO_W-1:0] sq;
  logic [BM_W:0]      two_p;
  logic [BM_W:0]      bm_next;
  logic               bneg_next;

  logic [A_W-1:0]     a;
  logic [BM_W-1:0]    bm;
  logic               bneg;
  front_flags_t       flags1;
  logic [SW-1:0]      side1;

  logic [PP_W-1:0]    pl;
  logic [PP_W-1:0]    ph;
  logic               hneg2;
  front_flags_t       flags2;
  logic [SW-1:0]      side2;

  logic [PROD_W-1:0]  prod;

  always_comb begin
    sq = (2 * QUO_W)'(quo) * (2 * QUO_W)'(quo);
    two_p = (BM_W + 1)'({quo, 1'b0});
    bneg_next = 1'b0;
    if (flags_in.uneg) begin
      bm_next = B_BASE + two_p;
    end else if (two_p > B_BASE) begin
      bm_next = two_p - B_BASE;
      bneg_next = 1'b1;
    end else begin
      bm_next = B_BASE - two_p;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a <= sq[2*QUO_W-1:FRAC];
      bm <= bm_next[BM_W-1:0];
      bneg <= bneg_next;
      flags1 <= flags_in;
      side1 <= side_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      pl <= PP_W'(a[A_LO_W-1:0]) * PP_W'(bm);
      ph <= PP_W'(a[A_W-1:A_LO_W]) * PP_W'(bm);
      hneg2 <= flags1.pmh ? !flags1.uneg : bneg;
      flags2 <= flags1;
      side2 <= side1;
    end
  end

  assign prod = (PROD_W'(ph) << A_LO_W) + PROD_W'(pl);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      coef.hm <= prod[LIMIT_EXP:FRAC];
      coef.huge <= flags2.pmh || (prod > LIMIT);
      coef.hneg <= hneg2;
      bad <= flags2.bad;
      side_out <= side2;
    end
  end

endmodule

### src/cjhi_lane.sv
module cjhi_lane #(
  parameter int AW = 20
) (
  input  logic                 clk,
  input  logic [2:0]           en,
  input  logic signed [AW-1:0] angle,
  input  logic [AW-1:0]        dmag,
  input  logic                 dneg,
  input  logic                 bad,
  input  cjhi_pkg::hcoef_t     coef,
  output logic signed [AW-1:0] pos
);
  import cjhi_pkg::*;

  localparam int PL_W = AW + HM_LO_W;
  localparam int PH_W = AW + HM_HI_W;
  localparam int SUM_W = (AW + HM_W + 1 > LIMIT_EXP + 2) ? AW + HM_W + 1 : LIMIT_EXP + 2;
  localparam int RW = HM_W + 2;
  localparam logic [SUM_W-1:0] RND = SUM_W'(1) << (FRAC - 1);
  localparam logic [SUM_W-1:0] SUM_LIMIT = (SUM_W'(1) << LIMIT_EXP) + RND;
  localparam logic signed [AW-1:0] AMAX = {1'b0, {(AW - 1){1'b1}}};
  localparam logic signed [AW-1:0] AMIN = {1'b1, {(AW - 1){1'b0}}};

  logic [PL_W-1:0]       pl;
  logic [PH_W-1:0]       ph;
  logic signed [AW-1:0]  s1;
  logic                  dnz1;
  logic                  neg1;
  logic                  huge1;
  logic                  bad1;

  logic [SUM_W-1:0]      sum;
  logic [HM_W-1:0]       delta;
  logic                  ovf2;
  logic signed [AW-1:0]  s2;
  logic                  dnz2;
  logic                  neg2;
  logic                  bad2;

  logic signed [RW-1:0]  r;
  logic signed [AW-1:0]  pos_next;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pl <= PL_W'(dmag) * PL_W'(coef.hm[HM_LO_W-1:0]);
      ph <= PH_W'(dmag) * PH_W'(coef.hm[HM_W-1:HM_LO_W]);
      s1 <= angle;
      dnz1 <= |dmag;
      neg1 <= dneg ^ coef.hneg;
      huge1 <= coef.huge;
      bad1 <= bad;
    end
  end

  assign sum = (SUM_W'(ph) << HM_LO_W) + SUM_W'(pl) + RND;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      delta <= sum[LIMIT_EXP:FRAC];
      ovf2 <= huge1 || (sum > SUM_LIMIT);
      s2 <= s1;
      dnz2 <= dnz1;
      neg2 <= neg1;
      bad2 <= bad1;
    end
  end

  always_comb begin
    if (neg2) begin
      r = RW'(s2) - $signed({2'b00, delta});
    end else begin
      r = RW'(s2) + $signed({2'b00, delta});
    end
    if (bad2) begin
      pos_next = s2;
    end else if (ovf2 && dnz2) begin
      pos_next = neg2 ? AMIN : AMAX;
    end else if (r > RW'(AMAX)) begin
      pos_next = AMAX;
    end else if (r < RW'(AMIN)) begin
      pos_next = AMIN;
    end else begin
      pos_next = r[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      pos <= pos_next;
    end
  end

endmodule

### src/cubic_joint_homing_interp.sv
// Throughput: one request per cycle unless out_ready stalls the output; a 31-bit
// quotient divider of eight stages, four restoring steps in each but the last,
// which has three, is the longest part of the pipeline.
// Stalls on the output fill bubbles first and never drop or repeat a request.
// Reset (rst, synchronous) empties the pipeline and loads home angles of +pi/2,
// except joint 1 which resets to -pi/2.
module cubic_joint_homing_interp #(
  parameter int ANGLE_WIDTH = 20,
  parameter int TIME_WIDTH = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [ANGLE_WIDTH-1:0]  start_angle_0,
  input  logic signed [ANGLE_WIDTH-1:0]  start_angle_1,
  input  logic signed [ANGLE_WIDTH-1:0]  start_angle_2,
  input  logic signed [ANGLE_WIDTH-1:0]  start_angle_3,
  input  logic signed [ANGLE_WIDTH-1:0]  start_angle_4,
  input  logic signed [ANGLE_WIDTH-1:0]  start_angle_5,
  input  logic [TIME_WIDTH-1:0]          time_now,
  input  logic [TIME_WIDTH-1:0]          time_begin,
  input  logic [TIME_WIDTH-1:0]          time_finish,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [ANGLE_WIDTH-1:0]  pos_angle_0,
  output logic signed [ANGLE_WIDTH-1:0]  pos_angle_1,
  output logic signed [ANGLE_WIDTH-1:0]  pos_angle_2,
  output logic signed [ANGLE_WIDTH-1:0]  pos_angle_3,
  output logic signed [ANGLE_WIDTH-1:0]  pos_angle_4,
  output logic signed [ANGLE_WIDTH-1:0]  pos_angle_5,
  output logic                           bad_interval,
  input  logic                           cfg_write,
  input  logic [cjhi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ANGLE_WIDTH-1:0]         cfg_data
);
  import cjhi_pkg::*;

  localparam int AW = ANGLE_WIDTH;
  localparam int TW = TIME_WIDTH;
  localparam int JW = 2 * AW + 1;
  localparam int LSW = JOINTS * JW;
  localparam int FW = $bits(front_flags_t);
  localparam int DSW = LSW + FW;

  logic [STAGES-1:0]    valid;
  logic [STAGES-1:0]    en;

  logic signed [AW-1:0] home [JOINTS];
  logic signed [AW-1:0] start [JOINTS];
  logic signed [AW-1:0] pos [JOINTS];

  logic signed [AW-1:0] f_angle [JOINTS];
  logic [AW-1:0]        f_dmag [JOINTS];
  logic [JOINTS-1:0]    f_dneg;
  logic [TW-1:0]        f_umag;
  logic [TW-1:0]        f_tspan;
  front_flags_t         f_flags;

  logic [LSW-1:0]       f_side;
  logic [DSW-1:0]       div_side_in;
  logic [DSW-1:0]       div_side;
  logic [QUO_W-1:0]     quo;
  front_flags_t         d_flags;

  hcoef_t               coef;
  logic                 p_bad;
  logic [LSW-1:0]       p_side;
  logic [2:0]           bad_pipe;

  assign start[0] = start_angle_0;
  assign start[1] = start_angle_1;
  assign start[2] = start_angle_2;
  assign start[3] = start_angle_3;
  assign start[4] = start_angle_4;
  assign start[5] = start_angle_5;

  assign pos_angle_0 = pos[0];
  assign pos_angle_1 = pos[1];
  assign pos_angle_2 = pos[2];
  assign pos_angle_3 = pos[3];
  assign pos_angle_4 = pos[4];
  assign pos_angle_5 = pos[5];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < JOINTS; j++) begin
        home[j] <= AW'(home_reset(j));
      end
    end else if (cfg_write) begin
      for (int j = 0; j < JOINTS; j++) begin
        if (cfg_index == CFG_IDX_W'(j)) begin
          home[j] <= cfg_data;
        end
      end
    end
  end

  always_comb begin
    en[STAGES-1] = !valid[STAGES-1] || out_ready;
    for (int i = STAGES - 2; i >= 0; i--) begin
      en[i] = !valid[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) begin
        valid[0] <= in_valid;
      end
      for (int i = 1; i < STAGES; i++) begin
        if (en[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  assign in_ready = en[0];
  assign out_valid = valid[STAGES-1];

  cjhi_front #(
    .AW(AW),
    .TW(TW)
  ) u_front (
    .clk         (clk),
    .en          (en[1:0]),
    .home        (home),
    .start       (start),
    .time_now    (time_now),
    .time_begin  (time_begin),
    .time_finish (time_finish),
    .angle       (f_angle),
    .dmag        (f_dmag),
    .dneg        (f_dneg),
    .umag        (f_umag),
    .tspan       (f_tspan),
    .flags       (f_flags)
  );

  for (genvar j = 0; j < JOINTS; j++) begin : g_pack
    assign f_side[j*JW +: JW] = {f_angle[j], f_dmag[j], f_dneg[j]};
  end

  assign div_side_in = {f_flags, f_side};

  cjhi_div #(
    .TW(TW),
    .SW(DSW)
  ) u_div (
    .clk      (clk),
    .en       (en[ST_DIV +: DIV_STAGES]),
    .tspan    (f_tspan),
    .umag     (f_umag),
    .side_in  (div_side_in),
    .quo      (quo),
    .side_out (div_side)
  );

  assign d_flags = div_side[DSW-1 -: FW];

  cjhi_poly #(
    .SW(LSW)
  ) u_poly (
    .clk      (clk),
    .en       (en[ST_POLY +: 3]),
    .quo      (quo),
    .flags_in (d_flags),
    .side_in  (div_side[LSW-1:0]),
    .coef     (coef),
    .bad      (p_bad),
    .side_out (p_side)
  );

  for (genvar j = 0; j < JOINTS; j++) begin : g_lane
    logic [JW-1:0] lside;

    assign lside = p_side[j*JW +: JW];

    cjhi_lane #(
      .AW(AW)
    ) u_lane (
      .clk   (clk),
      .en    (en[ST_LANE +: 3]),
      .angle (lside[JW-1 -: AW]),
      .dmag  (lside[AW:1]),
      .dneg  (lside[0]),
      .bad   (p_bad),
      .coef  (coef),
      .pos   (pos[j])
    );
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (en[ST_LANE + i]) begin
        bad_pipe[i] <= (i == 0) ? p_bad : bad_pipe[(i == 0) ? 0 : i - 1];
      end
    end
  end

  assign bad_interval = bad_pipe[2];

endmodule
